// ===== rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// shared constants and types of the closest pair distance unit
// ----------------------------------------------------------------------------
package cpd_pkg;
	localparam int MaxPoints = 1024;
	localparam int CoordBits = 24;
	localparam int AddrBits = $clog2(MaxPoints);
	localparam int CntBits = $clog2(MaxPoints + 1);
	localparam int SqBits = 50;
	localparam int DistBits = 25;
	localparam int DiffBits = CoordBits + 1;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic [SqBits-1:0] sq_t;
	typedef logic [DistBits-1:0] dist_t;
	typedef logic [AddrBits-1:0] addr_t;
	typedef logic [CntBits-1:0] cnt_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} point_t;

	typedef struct packed {
		dist_t min_distance;
		sq_t   min_squared;
		logic  no_pair;
		logic  overflowed;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_SQRT,
		ST_OUT
	} state_t;
endpackage

// ===== rtl/cpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface cpd_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cpd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module cpd_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/cpd_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_dist
// pipelined squared distance of two points, three stages, saturating
// ----------------------------------------------------------------------------
module cpd_dist (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cpd_pkg::coord_t ax,
	input  cpd_pkg::coord_t ay,
	input  cpd_pkg::coord_t bx,
	input  cpd_pkg::coord_t by,
	output logic           out_valid,
	output cpd_pkg::sq_t   sq
);
	import cpd_pkg::*;
	logic [DiffBits-1:0] dx_s1, dy_s1;
	logic [2*DiffBits-1:0] sx_s2, sy_s2;
	logic v_s1, v_s2, v_s3;
	sq_t sq_s3;
	logic signed [DiffBits-1:0] ddx, ddy;
	logic [2*DiffBits:0] sum;

	assign ddx = DiffBits'(ax) - DiffBits'(bx);
	assign ddy = DiffBits'(ay) - DiffBits'(by);
	assign sum = (2*DiffBits+1)'(sx_s2) + (2*DiffBits+1)'(sy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= ddx[DiffBits-1] ? DiffBits'(-ddx) : DiffBits'(ddx);
		dy_s1 <= ddy[DiffBits-1] ? DiffBits'(-ddy) : DiffBits'(ddy);
		sx_s2 <= dx_s1 * dx_s1;
		sy_s2 <= dy_s1 * dy_s1;
		if (sum > (2*DiffBits+1)'({SqBits{1'b1}})) sq_s3 <= '1;
		else sq_s3 <= SqBits'(sum);
	end

	assign out_valid = v_s3;
	assign sq = sq_s3;
endmodule

// ===== rtl/cpd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_sqrt
// restoring integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module cpd_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cpd_pkg::sq_t      value,
	output logic              busy,
	output cpd_pkg::dist_t    root
);
	import cpd_pkg::*;
	localparam int Steps = SqBits / 2;
	localparam int StepBits = $clog2(Steps + 1);
	sq_t rem_q;
	logic [SqBits-1:0] res_q;
	logic [SqBits-1:0] bit_q;
	logic [StepBits-1:0] cnt_q;
	logic [SqBits-1:0] trial;

	assign trial = res_q + bit_q;
	assign busy = cnt_q != '0;
	assign root = DistBits'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= StepBits'(Steps);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= SqBits'(1) << (SqBits - 2);
		end else if (busy) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ===== rtl/closest_pair_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_distance_unit
// stores points in ram, compares each point it can store with all stored ones
// ----------------------------------------------------------------------------
// channel   dir   beat
// pt        in    point_x, point_y, last_point
// res       out   min_distance, min_squared, no_pair, overflowed
//
// after each accepted beat the unit makes one ram read per stored point, ends
// the scan, drains the distance pipeline, writes the point back and returns
// to idle before it takes the next beat; a last point adds the square root
// and the result beat, which waits for res.ready; a dropped point skips the
// reads and the drain; no clearing pass after reset
// ----------------------------------------------------------------------------
module closest_pair_distance_unit (
	input logic clk,
	input logic arst_n,
	cpd_if.sink   pt,
	cpd_if.source res
);
	import cpd_pkg::*;
	state_t state_q, state_nx;
	point_t cur_q;
	cnt_t count_q, rd_q;
	sq_t best_q;
	logic drop_q;
	logic [1:0] drain_q;
	result_t res_q;
	coord_t xr, yr;
	logic rd_valid_s1;
	logic dv;
	sq_t dsq;
	logic sqrt_start;
	logic sqrt_busy;
	dist_t root;
	logic rd_en;
	logic wr_en;
	logic accept;

	assign accept = pt.valid && pt.ready;
	assign rd_en = state_q == ST_SCAN && count_q != cnt_t'(MaxPoints) && rd_q < count_q;
	assign wr_en = state_q == ST_WRITE && count_q != cnt_t'(MaxPoints);

	cpd_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_x (
		.clk(clk), .we(wr_en), .waddr(AddrBits'(count_q)),
		.wdata(cur_q.x), .raddr(AddrBits'(rd_q)), .rdata(xr));
	cpd_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_y (
		.clk(clk), .we(wr_en), .waddr(AddrBits'(count_q)),
		.wdata(cur_q.y), .raddr(AddrBits'(rd_q)), .rdata(yr));

	cpd_dist u_dist (
		.clk(clk), .arst_n(arst_n), .in_valid(rd_valid_s1),
		.ax(xr), .ay(yr), .bx(cur_q.x), .by(cur_q.y),
		.out_valid(dv), .sq(dsq));

	assign sqrt_start = state_q == ST_WRITE && cur_q.last;
	cpd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .value(best_q),
		.busy(sqrt_busy), .root(root));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nx = ST_SCAN;
			ST_SCAN: if (count_q == cnt_t'(MaxPoints)) state_nx = ST_WRITE;
				else if (!rd_en) state_nx = ST_DRAIN;
			ST_DRAIN: if (drain_q == 2'd0 && !dv) state_nx = ST_WRITE;
			ST_WRITE: state_nx = cur_q.last ? ST_SQRT : ST_IDLE;
			ST_SQRT: if (!sqrt_busy) state_nx = ST_OUT;
			ST_OUT: if (res.ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		pt.ready = state_q == ST_IDLE;
		res.valid = state_q == ST_OUT;
		res.data = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			best_q <= '1;
			drop_q <= 1'b0;
			rd_q <= '0;
			drain_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_nx;
			rd_valid_s1 <= rd_en;
			if (accept) begin
				rd_q <= '0;
				drain_q <= 2'd3;
			end else if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (state_q == ST_DRAIN && drain_q != 2'd0) drain_q <= drain_q - 1'b1;
			if (dv && dsq < best_q) best_q <= dsq;
			if (state_q == ST_WRITE) begin
				if (count_q == cnt_t'(MaxPoints)) drop_q <= 1'b1;
				else count_q <= count_q + 1'b1;
			end
			if (state_q == ST_OUT && res.ready) begin
				count_q <= '0;
				best_q <= '1;
				drop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q.x <= pt.data.x;
			cur_q.y <= pt.data.y;
			cur_q.last <= pt.data.last;
		end
		if (state_q == ST_SQRT && !sqrt_busy) begin
			res_q.no_pair <= count_q < cnt_t'(2);
			res_q.min_squared <= count_q < cnt_t'(2) ? '0 : best_q;
			res_q.min_distance <= count_q < cnt_t'(2) ? '0 : root;
			res_q.overflowed <= drop_q;
		end
	end
endmodule

// ===== rtl/cpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_checker
// port level checks of the closest pair distance unit
// ----------------------------------------------------------------------------
module cpd_checker (
	input logic clk,
	input logic arst_n,
	input logic pt_valid,
	input logic pt_ready,
	input logic res_valid,
	input logic res_ready,
	input logic no_pair,
	input logic [49:0] min_squared,
	input logic [24:0] min_distance
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(min_squared))
		else $error("result beat dropped while stalled");
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !pt_ready)
		else $error("point taken while result pending");
	a_nopair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && no_pair |-> min_squared == 50'd0 && min_distance == 25'd0)
		else $error("no pair result not zero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_ready |=> !pt_ready)
		else $error("ready right after accepted point");
endmodule

bind closest_pair_distance_unit cpd_checker u_cpd_checker (
	.clk(clk), .arst_n(arst_n), .pt_valid(pt.valid), .pt_ready(pt.ready),
	.res_valid(res.valid), .res_ready(res.ready), .no_pair(res.data.no_pair),
	.min_squared(res.data.min_squared), .min_distance(res.data.min_distance));

// ===== verif/tb_closest_pair_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_pair_distance_unit
// self-checking bench of the closest pair distance unit: point sets are
// streamed in, a local all-pairs search or a typed row gives each expected
// result beat, compared field by field under random stalls on both channels
// ----------------------------------------------------------------------------
module tb_closest_pair_distance_unit;
	import cpd_pkg::*;

	localparam int IdleLimit = 20000;
	localparam int LongHold = 400;
	localparam longint unsigned SqMask = (64'd1 << SqBits) - 1;

	typedef struct {
		point_t  pt;
		logic    typed;
		result_t res;
	} stim_row_t;

	typedef struct packed {
		logic    typed;
		result_t res;
	} tag_t;

	logic clk;
	logic arst_n;

	cpd_if #(.payload_t(point_t))  pt_ch ();
	cpd_if #(.payload_t(result_t)) res_ch ();

	closest_pair_distance_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt_ch),
		.res    (res_ch)
	);

	longint  stored_x [MaxPoints];
	longint  stored_y [MaxPoints];
	int      stored_cnt;
	longint unsigned best_sq;
	bit      dropped;

	result_t pending_q [$];
	tag_t    tag_q [$];
	int      fail_cnt;
	int      idle_cycles;
	bit      quiet;
	int      hold_req;

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// all-pairs closest distance, returns 1 when a result beat follows
	function automatic bit closest_pair_step(point_t p, output result_t r);
		longint px, py, dx, dy;
		longint unsigned s;
		px = longint'(p.x);
		py = longint'(p.y);
		r = '0;
		if (stored_cnt < MaxPoints) begin
			for (int i = 0; i < stored_cnt; i++) begin
				dx = stored_x[i] - px;
				dy = stored_y[i] - py;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				s = longint'(dx * dx) + longint'(dy * dy);
				if (s > SqMask) s = SqMask;
				if (s < best_sq) best_sq = s;
			end
			stored_x[stored_cnt] = px;
			stored_y[stored_cnt] = py;
			stored_cnt++;
		end else begin
			dropped = 1'b1;
		end
		if (!p.last) return 1'b0;
		if (stored_cnt < 2) begin
			r.no_pair = 1'b1;
		end else begin
			r.min_distance = dist_t'(isqrt(best_sq));
			r.min_squared = sq_t'(best_sq);
		end
		r.overflowed = dropped;
		stored_cnt = 0;
		best_sq = SqMask;
		dropped = 1'b0;
		return 1'b1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// monitor: prediction on input beats, checking on result beats, watchdog
	always @(posedge clk) begin
		result_t r, e;
		tag_t t;
		if (arst_n) begin
			idle_cycles++;
			if (pt_ch.valid && pt_ch.ready) begin
				idle_cycles = 0;
				t = tag_q.pop_front();
				if (closest_pair_step(pt_ch.data, r))
					pending_q = {pending_q, (t.typed ? t.res : r)};
			end
			if (res_ch.valid && res_ch.ready) begin
				idle_cycles = 0;
				r = res_ch.data;
				if (pending_q.size() == 0) begin
					$error("result beat with nothing expected");
					fail_cnt++;
				end else begin
					e = pending_q.pop_front();
					if (r.min_distance !== e.min_distance) begin
						$error("min_distance exp %0d got %0d", e.min_distance, r.min_distance);
						fail_cnt++;
					end
					if (r.min_squared !== e.min_squared) begin
						$error("min_squared exp %0d got %0d", e.min_squared, r.min_squared);
						fail_cnt++;
					end
					if (r.no_pair !== e.no_pair) begin
						$error("no_pair exp %0d got %0d", e.no_pair, r.no_pair);
						fail_cnt++;
					end
					if (r.overflowed !== e.overflowed) begin
						$error("overflowed exp %0d got %0d", e.overflowed, r.overflowed);
						fail_cnt++;
					end
				end
			end
			if (idle_cycles >= IdleLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// result side stalls
	initial begin
		int stall, hold;
		stall = 0;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (quiet) begin
				res_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send(point_t p, logic typed = 1'b0, result_t tr = '0);
		tag_t t;
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			pt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		t.typed = typed;
		t.res = tr;
		tag_q = {tag_q, t};
		pt_ch.valid <= 1'b1;
		pt_ch.data <= p;
		do @(posedge clk); while (!pt_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		pt_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
			default: return $urandom_range(0, 1) ? coord_t'(24'h7fffff - $urandom_range(0, 255))
				: coord_t'(24'h800000 + $urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_set(int n);
		point_t p;
		int mode;
		mode = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 9) == 0) begin
				p.x = coord_t'(stored_x[0]);
				p.y = coord_t'(stored_y[0]);
			end else begin
				p.x = rand_coord(mode);
				p.y = rand_coord(mode);
			end
			p.last = (i == n - 1);
			send(p);
		end
	endtask

	stim_row_t rows [$];

	task automatic add_row(int x, int y, logic last, logic typed = 1'b0,
			int d = 0, longint sq = 0, logic np = 0);
		stim_row_t s;
		s.pt.x = coord_t'(x);
		s.pt.y = coord_t'(y);
		s.pt.last = last;
		s.typed = typed;
		s.res.min_distance = dist_t'(d);
		s.res.min_squared = sq_t'(sq);
		s.res.no_pair = np;
		s.res.overflowed = 1'b0;
		rows = {rows, s};
	endtask

	initial begin
		int n, count;
		bit held, paused;
		fail_cnt = 0;
		idle_cycles = 0;
		quiet = 0;
		hold_req = 0;
		stored_cnt = 0;
		best_sq = SqMask;
		dropped = 0;
		held = 0;
		paused = 0;
		arst_n = 1'b0;
		pt_ch.valid = 1'b0;
		pt_ch.data = '0;

		// lone point, duplicates, a step of 256, extremes, mixed signs
		add_row(5, -7, 1, 1, 0, 0, 1);
		add_row(-300, 900, 0);
		add_row(-300, 900, 1, 1, 0, 0, 0);
		add_row(0, 0, 0);
		add_row(256, 0, 1, 1, 256, 65536, 0);
		add_row(-8388608, -8388608, 0);
		add_row(8388607, 8388607, 1);
		add_row(0, -8388608, 0);
		add_row(0, 8388607, 1);
		add_row(8388607, -8388608, 0);
		add_row(-8388608, 8388607, 0);
		add_row(-1, -1, 0);
		add_row(1, 1, 1);
		add_row(1000, -2000, 0);
		add_row(-1000, 2000, 0);
		add_row(999, -1998, 0);
		add_row(-8388608, 0, 1);
		add_row(8388607, 0, 1, 1, 0, 0, 1);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) send(rows[i].pt, rows[i].typed, rows[i].res);
		wait_drained();

		// random sets, with one long result stall and one full drain
		count = 0;
		while (count < 120) begin
			if (!held && count > 30) begin
				hold_req = LongHold;
				held = 1;
			end
			if (count > 100) quiet = 1;
			case ($urandom_range(0, 9))
				0: n = 1;
				1: n = $urandom_range(9, 40);
				default: n = $urandom_range(2, 8);
			endcase
			send_set(n);
			count += n;
			if (!paused && count > 60) begin
				paused = 1;
				wait_drained();
				repeat ($urandom_range(5, 40)) @(negedge clk);
			end
		end
		wait_drained();
		quiet = 0;

		// full store plus dropped points, the dropped last one ends the set
		send_set(MaxPoints + 2);
		wait_drained();

		quiet = 1;
		send_set(3);
		send_set(1);
		wait_drained();
		repeat (60) @(posedge clk);

		if (fail_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== closest_pair_distance_unit.f =====
rtl/cpd_pkg.sv
rtl/cpd_if.sv
rtl/cpd_ram.sv
rtl/cpd_dist.sv
rtl/cpd_sqrt.sv
rtl/closest_pair_distance_unit.sv
rtl/cpd_checker.sv
verif/tb_closest_pair_distance_unit.sv
